FILE: rtl/core/pab_pkg.sv
// pab_pkg: shared types and constants of the page bitmap allocator.
// Used by page_bitmap_allocator and by its port checker.
// No dependencies.
`default_nettype none

package pab_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  // Default map size in pages
  localparam int unsigned NUM_PAGES_DEF = 4096;

  // Used counter saturation value
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register reset values
  localparam logic [COUNT_W-1:0] PAGE_COUNT_RST   = '0;
  localparam logic [ADDR_W-1:0]  REGION_START_RST = 32'h0010_0000;
  localparam logic [ADDR_W-1:0]  REGION_END_RST   = 32'h0010_0000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 2'd2;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_e;

endpackage : pab_pkg

`default_nettype wire

FILE: rtl/core/page_bitmap_allocator.sv
// page_bitmap_allocator: bitmap page frame allocator, one used bit per 4 KiB page.
// The map lives in a 32-bit wide synchronous memory; depends on pab_pkg.
// Checked by pab_checker (bound from pab_checker.sv).
//
//  channel | signals                              | direction | handshake
//  --------+--------------------------------------+-----------+-----------
//  request | opcode_i, free_address_i             | in        | in_valid_i / in_ready_o
//  result  | status_o, page_address_o, used_pages_o | out     | out_valid_o / out_ready_i
//  config  | cfg_index_i, cfg_data_i              | in        | cfg_we_i, no wait
//
// Allocate: a start state, then a scan of the 32-bit map words, one word read per
// cycle from the map memory, then the result.
// Free: range check, word read, modify, write back with the result; a rejected
// address skips the word read and the modify.
// After reset a clearing pass writes zero to every map word, with in_ready_o low.
// One request is in process at a time; a new one is taken while the previous
// result waits in the output register. A stalled result holds the write back.
`default_nettype none

module page_bitmap_allocator
  import pab_pkg::*;
#(
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_data_i,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 opcode_i,
  input  wire logic [ADDR_W-1:0]    free_address_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                status_o,
  output logic [ADDR_W-1:0]         page_address_o,
  output logic [COUNT_W-1:0]        used_pages_o
);

  localparam int unsigned MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PIDX_W    = ADDR_W - PAGE_SHIFT;
  // scan indexes stay below 2^COUNT_W, so the scan word index is narrow
  localparam int unsigned SW_W      = COUNT_W - 5;
  localparam logic [WA_W-1:0]    LAST_WORD = WA_W'(MAP_WORDS - 1);
  localparam logic [COUNT_W-1:0] NP_CNT    = COUNT_W'(NUM_PAGES);

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ASTART = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FCHK   = 3'd4;
  localparam logic [2:0] S_FMOD   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [WA_W-1:0]    clr_q;
  logic [COUNT_W-1:0] used_q, used_d;
  logic [COUNT_W-1:0] page_count_q;
  logic [ADDR_W-1:0]  region_start_q, region_end_q;

  // pending request and result
  logic [ADDR_W-1:0]  free_addr_q;
  logic [SW_W-1:0]    scan_w_q;
  logic               first_q;
  logic [4:0]         fbit_q;
  status_e            res_status_q;
  logic [ADDR_W-1:0]  res_addr_q;
  logic               wr_q, inc_q, dec_q;
  logic [WA_W-1:0]    waddr_q;
  logic [31:0]        wdata_q;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COUNT_W-1:0] out_used_q;

  // map memory
  logic [31:0]        map_mem [MAP_WORDS];
  logic [31:0]        rdata_q;
  logic               mem_re, mem_we;
  logic [WA_W-1:0]    mem_raddr, mem_waddr;
  logic [31:0]        mem_wdata;

  logic               in_fire, done_fire;

  // search limit: page count capped at the map size
  logic [COUNT_W-1:0] lim;
  always_comb begin
    if ({4'b0, page_count_q} > 17'(NUM_PAGES)) begin
      lim = NP_CNT;
    end else begin
      lim = page_count_q;
    end
  end

  // scan of one map word: pages outside [used count, limit) count as used
  logic [31:0]        hi_ok, lo_ok, free_bits;
  logic [4:0]         pos;
  logic               found;
  logic [SW_W:0]      next_w;
  logic               next_has;
  logic [COUNT_W-1:0] found_idx;
  logic [ADDR_W-1:0]  alloc_addr;

  always_comb begin
    hi_ok = (scan_w_q == lim[COUNT_W-1:5]) ? ((32'd1 << lim[4:0]) - 32'd1) : '1;
    lo_ok = first_q ? ~((32'd1 << used_q[4:0]) - 32'd1) : '1;
    free_bits = ~rdata_q & hi_ok & lo_ok;
    found = |free_bits;
    pos = '0;
    for (int b = 31; b >= 0; b--) begin
      if (free_bits[b]) begin
        pos = 5'(b);
      end
    end
    found_idx  = {scan_w_q, pos};
    alloc_addr = region_start_q + (ADDR_W'(found_idx) << PAGE_SHIFT);
    next_w     = {1'b0, scan_w_q} + 1'b1;
    next_has   = {next_w, 5'b0} < {1'b0, lim};
  end

  // free address check
  logic [ADDR_W-1:0] diff;
  logic [PIDX_W-1:0] pidx;
  logic              free_bad;
  always_comb begin
    diff     = free_addr_q - region_start_q;
    pidx     = diff[ADDR_W-1:PAGE_SHIFT];
    free_bad = (free_addr_q < region_start_q) || (free_addr_q > region_end_q) ||
               (pidx >= PIDX_W'(NUM_PAGES));
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign done_fire  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // memory read port: one word per cycle while scanning
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      S_ASTART: begin
        mem_re    = (used_q < lim);
        mem_raddr = WA_W'(used_q[COUNT_W-1:5]);
      end
      S_SCAN: begin
        mem_re    = !found && next_has;
        mem_raddr = WA_W'(next_w[SW_W-1:0]);
      end
      S_FCHK: begin
        mem_re    = !free_bad;
        mem_raddr = WA_W'(pidx[PIDX_W-1:5]);
      end
      default: begin
        mem_re    = 1'b0;
        mem_raddr = '0;
      end
    endcase
  end

  // memory write port: clearing pass or write back with the result.
  // The write back happens before the next request is taken, so no read
  // can overlap a pending write to the same word.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr_q;
    mem_wdata = wdata_q;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (done_fire && wr_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[mem_raddr];
    end
  end

  // used count after the current result
  always_comb begin
    used_d = used_q;
    if (inc_q && (used_q != COUNT_MAX)) begin
      used_d = used_q + 1'b1;
    end else if (dec_q && (used_q != '0)) begin
      used_d = used_q - 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == LAST_WORD) state_d = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          state_d = (opcode_i == OP_FREE) ? S_FCHK : S_ASTART;
        end
      end
      S_ASTART: state_d = (used_q < lim) ? S_SCAN : S_DONE;
      S_SCAN:   if (found || !next_has) state_d = S_DONE;
      S_FCHK:   state_d = free_bad ? S_DONE : S_FMOD;
      S_FMOD:   state_d = S_DONE;
      S_DONE:   if (done_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      used_q         <= '0;
      out_valid_q    <= 1'b0;
      wr_q           <= 1'b0;
      inc_q          <= 1'b0;
      dec_q          <= 1'b0;
      page_count_q   <= PAGE_COUNT_RST;
      region_start_q <= REGION_START_RST;
      region_end_q   <= REGION_END_RST;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PAGE_COUNT:   page_count_q   <= cfg_data_i[COUNT_W-1:0];
          REG_REGION_START: region_start_q <= cfg_data_i;
          REG_REGION_END:   region_end_q   <= cfg_data_i;
          default:          ;
        endcase
      end
      // result kind, settled before S_DONE
      case (state_q)
        S_ASTART: begin
          wr_q  <= 1'b0;
          inc_q <= 1'b0;
          dec_q <= 1'b0;
        end
        S_SCAN: begin
          wr_q  <= found;
          inc_q <= found;
          dec_q <= 1'b0;
        end
        S_FCHK: begin
          wr_q  <= 1'b0;
          inc_q <= 1'b0;
          dec_q <= 1'b0;
        end
        S_FMOD: begin
          wr_q  <= 1'b1;
          dec_q <= 1'b1;
        end
        default: ;
      endcase
      if (done_fire) begin
        used_q <= used_d;
      end
      // output register
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      free_addr_q <= free_address_i;
    end
    case (state_q)
      S_ASTART: begin
        scan_w_q     <= used_q[COUNT_W-1:5];
        first_q      <= 1'b1;
        res_status_q <= ST_OOM;
        res_addr_q   <= '0;
      end
      S_SCAN: begin
        scan_w_q <= next_w[SW_W-1:0];
        first_q  <= 1'b0;
        waddr_q  <= WA_W'(scan_w_q);
        wdata_q  <= rdata_q | (32'd1 << pos);
        if (found) begin
          res_status_q <= ST_OK;
          res_addr_q   <= alloc_addr;
        end else begin
          res_status_q <= ST_OOM;
          res_addr_q   <= '0;
        end
      end
      S_FCHK: begin
        fbit_q       <= pidx[4:0];
        waddr_q      <= WA_W'(pidx[PIDX_W-1:5]);
        res_status_q <= free_bad ? ST_BAD : ST_OK;
        res_addr_q   <= '0;
      end
      S_FMOD: begin
        wdata_q <= rdata_q & ~(32'd1 << fbit_q);
      end
      default: ;
    endcase
    if (done_fire) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_used_q   <= used_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign page_address_o = out_addr_q;
  assign used_pages_o   = out_used_q;

endmodule : page_bitmap_allocator

`default_nettype wire

FILE: rtl/core/pab_checker.sv
// pab_checker: port level assertions for page_bitmap_allocator.
// Depends on pab_pkg; attached to the top level by the bind at the end.
`default_nettype none

module pab_checker
  import pab_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [1:0]           status_o,
  input wire logic [ADDR_W-1:0]    page_address_o,
  input wire logic [COUNT_W-1:0]   used_pages_o
);

  logic               in_fire, out_fire;
  logic [1:0]         cnt_q;
  logic [COUNT_W-1:0] last_used_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // transactions taken but not yet answered, and the last count delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_used_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire) begin
        last_used_q <= used_pages_o;
      end
    end
  end

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(page_address_o) && $stable(used_pages_o))
    else $error("result changed while stalled");

  // every result belongs to a request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 2'd0)
    else $error("result without request");

  // one request in process plus one waiting result at most
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> cnt_q < 2'd2)
    else $error("request taken with two outstanding");

  // failed requests return no address and leave the count alone
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (status_o != ST_OK) |->
    (page_address_o == '0) && (used_pages_o == last_used_q))
    else $error("failed request changed state or returned an address");

  // the map clearing pass blocks requests right after reset
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("request taken during clearing pass");

endmodule : pab_checker

bind page_bitmap_allocator pab_checker u_pab_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .page_address_o (page_address_o),
  .used_pages_o   (used_pages_o)
);

`default_nettype wire
